// ===== rtl/planckian_locus_chromaticity_macros.svh =====
// Assertion macros for the chromaticity block
`ifndef PLANCKIAN_LOCUS_CHROMATICITY_MACROS_SVH
`define PLANCKIAN_LOCUS_CHROMATICITY_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PLC_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define PLC_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define PLC_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`define PLC_ASSERT_NEXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/plc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;
	localparam int TempW = 15;
	localparam int OutW  = 16;
	localparam int XSplit = 4000;
	localparam int YSplit = 2222;

	// coefficient range selectors travelling down the pipe
	typedef struct packed {
		logic x_high;
		logic y_low;
		logic y_high;
	} range_sel_t;

	// decimal coefficients scaled by 1e8, order c3, c2, c1, c0
	typedef longint coef_set_t [4];

	// round a 1e8-scaled decimal to f fractional bits, half away from zero
	function automatic longint to_fixed(input longint dec, input int f);
		longint mag;
		longint r;
		mag = (dec < 0) ? -dec : dec;
		r = (mag * (longint'(1) << f) + 64'sd50000000) / 64'sd100000000;
		return (dec < 0) ? -r : r;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/plc_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: u = (1000*2^F + T/2) / T, one quotient bit per stage.
module plc_recip
	import plc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int QW = FRAC_BITS + 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [TempW-1:0]      in_temp,
	output logic                       out_valid,
	output logic [TempW-1:0]           out_temp,
	output logic [FRAC_BITS:0]         out_u
);
	localparam int NW = QW;
	localparam int RW = TempW + 1;
	logic [QW:0]       v_q;
	logic [NW-1:0]     n_q   [QW+1];
	logic [QW-1:0]     qt_q  [QW+1];
	logic [RW-1:0]     r_q   [QW+1];
	logic [TempW-1:0]  t_q   [QW+1];

	// load the dividend
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q[0] <= 1'b0;
		else v_q[0] <= in_valid;
	end
	always_ff @(posedge clk) begin
		n_q[0]  <= NW'((longint'(1000) << FRAC_BITS) + longint'(in_temp >> 1));
		qt_q[0] <= '0;
		r_q[0]  <= '0;
		t_q[0]  <= in_temp;
	end

	// one quotient bit per stage, MSB first
	for (genvar i = 0; i < QW; i++) begin : g_div
		logic [RW-1:0] sh;
		logic [RW:0]   df;
		assign sh = {r_q[i][RW-2:0], n_q[i][NW-1-i]};
		assign df = {1'b0, sh} - {2'b0, t_q[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else v_q[i+1] <= v_q[i];
		end
		always_ff @(posedge clk) begin
			n_q[i+1] <= n_q[i];
			t_q[i+1] <= t_q[i];
			if (!df[RW]) begin
				r_q[i+1]  <= df[RW-1:0];
				qt_q[i+1] <= qt_q[i] | (QW'(1) << (QW-1-i));
			end else begin
				r_q[i+1]  <= sh;
				qt_q[i+1] <= qt_q[i];
			end
		end
	end

	// saturate; zero divisor yields all ones, which saturates too
	assign out_valid = v_q[QW];
	assign out_temp  = t_q[QW];
	assign out_u = (qt_q[QW] > QW'({(FRAC_BITS+1){1'b1}})) ?
		{(FRAC_BITS+1){1'b1}} : qt_q[QW][FRAC_BITS:0];
endmodule
`default_nettype wire

// ===== rtl/plc_cubic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipelined cubic c3*p^3+c2*p^2+c1*p+c0, clamped to [0, 2^F-1]; select picks a set.
module plc_cubic
	import plc_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int PW = FRAC_BITS + 1,
	parameter longint C0A = 0, parameter longint C1A = 0,
	parameter longint C2A = 0, parameter longint C3A = 0,
	parameter longint C0B = 0, parameter longint C1B = 0,
	parameter longint C2B = 0, parameter longint C3B = 0,
	parameter longint C0C = 0, parameter longint C1C = 0,
	parameter longint C2C = 0, parameter longint C3C = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [1:0]            in_set,
	input  wire logic [PW-1:0]         in_p,
	input  wire range_sel_t            in_sel,
	input  wire logic [TempW-1:0]      in_temp,
	output logic                       out_valid,
	output range_sel_t                 out_sel,
	output logic [TempW-1:0]           out_temp,
	output logic [FRAC_BITS-1:0]       out_v
);
	localparam int CW = FRAC_BITS + 4;
	localparam int P2W = 2*PW - FRAC_BITS + 1;
	localparam int AW = CW + 2*PW + 4;
	localparam longint Half = longint'(1) << (FRAC_BITS-1);

	function automatic logic signed [CW-1:0] coef(input logic [1:0] s, input int k);
		longint a [4];
		longint b [4];
		longint c [4];
		a = '{C3A, C2A, C1A, C0A};
		b = '{C3B, C2B, C1B, C0B};
		c = '{C3C, C2C, C1C, C0C};
		case (s)
			2'd0:    return CW'(to_fixed(a[k], FRAC_BITS));
			2'd1:    return CW'(to_fixed(b[k], FRAC_BITS));
			default: return CW'(to_fixed(c[k], FRAC_BITS));
		endcase
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;
	logic [1:0] set_s1, set_s2, set_s3;
	range_sel_t sel_s1, sel_s2, sel_s3, sel_s4;
	logic [TempW-1:0] t_s1, t_s2, t_s3, t_s4;
	logic [PW-1:0] p_s1, p_s2;
	logic [P2W-1:0] p2_s1, p2_s2;
	logic [P2W:0] p3_s2;
	logic signed [AW-1:0] a3_s3, a2_s3, a1_s3;
	logic signed [AW-1:0] acc_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// square, cube, coefficient products, sum
	always_ff @(posedge clk) begin
		set_s1 <= in_set; sel_s1 <= in_sel; t_s1 <= in_temp; p_s1 <= in_p;
		p2_s1 <= P2W'(({{PW{1'b0}}, in_p} * {{PW{1'b0}}, in_p} + (2*PW)'(Half)) >> FRAC_BITS);
		set_s2 <= set_s1; sel_s2 <= sel_s1; t_s2 <= t_s1; p_s2 <= p_s1; p2_s2 <= p2_s1;
		p3_s2 <= (P2W+1)'(({{PW{1'b0}}, p2_s1} * {{P2W{1'b0}}, p_s1} + (P2W+PW)'(Half))
			>> FRAC_BITS);
		set_s3 <= set_s2; sel_s3 <= sel_s2; t_s3 <= t_s2;
		a3_s3 <= AW'(coef(set_s2, 0)) * AW'(signed'({1'b0, p3_s2}));
		a2_s3 <= AW'(coef(set_s2, 1)) * AW'(signed'({1'b0, p2_s2}));
		a1_s3 <= AW'(coef(set_s2, 2)) * AW'(signed'({1'b0, p_s2}));
		sel_s4 <= sel_s3; t_s4 <= t_s3;
		acc_s4 <= a3_s3 + a2_s3 + a1_s3 + (AW'(coef(set_s3, 3)) <<< FRAC_BITS) + AW'(Half);
	end

	// round by arithmetic shift (floor), then clamp
	logic signed [AW-1:0] r;
	assign r = acc_s4 >>> FRAC_BITS;
	assign out_valid = v_s4;
	assign out_sel = sel_s4;
	assign out_temp = t_s4;
	assign out_v = r[AW-1] ? '0 :
		(r > AW'({FRAC_BITS{1'b1}})) ? {FRAC_BITS{1'b1}} : r[FRAC_BITS-1:0];
endmodule
`default_nettype wire

// ===== rtl/planckian_locus_chromaticity.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                          Transfer
// input     start, busy, temp_kelvin       start && !busy
// result    done, chroma_x, chroma_y       done (one cycle)
// One temperature enters every cycle; busy stays low. done rises after the
// FRAC_BITS+11 register stages in the reciprocal divider (input load plus one
// quotient bit a stage), four for each of the two cubic pipelines, and one
// output register. Reset clears only the valid bits.
// The receiver cannot stall, so nothing is held back.
module planckian_locus_chromaticity
	import plc_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [TempW-1:0]  temp_kelvin,
	output logic                   done,
	output logic [OutW-1:0]        chroma_x,
	output logic [OutW-1:0]        chroma_y
);
`include "planckian_locus_chromaticity_macros.svh"
	logic dv;
	logic [TempW-1:0] dt;
	logic [FRAC_BITS:0] du;
	range_sel_t dsel;
	logic xv, yv;
	range_sel_t xsel, ysel;
	logic [TempW-1:0] xt, yt;
	logic [FRAC_BITS-1:0] xval, yval;
	logic [FRAC_BITS-1:0] x_d [4];
	logic [OutW-1:0] qx, qy;

	assign busy = 1'b0;

	plc_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk, .arst_n, .in_valid(start), .in_temp(temp_kelvin),
		.out_valid(dv), .out_temp(dt), .out_u(du)
	);

	// classify the temperature range
	assign dsel.x_high = (dt >= TempW'(XSplit));
	assign dsel.y_low  = (dt < TempW'(YSplit));
	assign dsel.y_high = (dt >= TempW'(XSplit));

	plc_cubic #(.FRAC_BITS(FRAC_BITS), .PW(FRAC_BITS+1),
		.C3A(-26612390), .C2A(-23435890), .C1A(87769560), .C0A(17991000),
		.C3B(-302584690), .C2B(210703790), .C1B(22263470), .C0B(24039000),
		.C3C(-302584690), .C2C(210703790), .C1C(22263470), .C0C(24039000)
	) u_xcubic (
		.clk, .arst_n, .in_valid(dv), .in_set({1'b0, dsel.x_high}), .in_p(du),
		.in_sel(dsel), .in_temp(dt), .out_valid(xv), .out_sel(xsel), .out_temp(xt),
		.out_v(xval)
	);

	plc_cubic #(.FRAC_BITS(FRAC_BITS), .PW(FRAC_BITS),
		.C3A(-110638140), .C2A(-134811020), .C1A(218555832), .C0A(-20219683),
		.C3B(-95494760), .C2B(-137418593), .C1B(209137015), .C0B(-16748867),
		.C3C(308175800), .C2C(-587338670), .C1C(375112997), .C0C(-37001483)
	) u_ycubic (
		.clk, .arst_n, .in_valid(xv),
		.in_set(xsel.y_low ? 2'd0 : (xsel.y_high ? 2'd2 : 2'd1)), .in_p(xval),
		.in_sel(xsel), .in_temp(xt), .out_valid(yv), .out_sel(ysel), .out_temp(yt),
		.out_v(yval)
	);

	// delay x alongside the y cubic
	always_ff @(posedge clk) begin
		x_d[0] <= xval; x_d[1] <= x_d[0]; x_d[2] <= x_d[1]; x_d[3] <= x_d[2];
	end

	// scale to Q0.16
	function automatic logic [OutW-1:0] to_q16(input logic [FRAC_BITS-1:0] v);
		logic [FRAC_BITS:0] r;
		if (FRAC_BITS > OutW) begin
			r = ({1'b0, v} + (FRAC_BITS+1)'(1 << (FRAC_BITS-OutW-1))) >> (FRAC_BITS-OutW);
			return (r > (FRAC_BITS+1)'(16'hFFFF)) ? 16'hFFFF : OutW'(r);
		end else begin
			return OutW'({v, {OutW{1'b0}}} >> FRAC_BITS);
		end
	endfunction

	assign qx = to_q16(x_d[3]);
	assign qy = to_q16(yval);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= yv;
	end
	always_ff @(posedge clk) begin
		chroma_x <= qx;
		chroma_y <= qy;
	end

	`PLC_ASSERT_IMPL(a_ysel_consistent, clk, arst_n, yv,
		!(ysel.y_low && ysel.y_high) && (ysel.x_high == ysel.y_high),
		"range selects inconsistent")
	`PLC_ASSERT_IMPL(a_temp_class, clk, arst_n, yv,
		ysel.y_low == (yt < TempW'(YSplit)), "range select lost its temperature")
	`PLC_ASSERT_NEXT(a_done_follows, clk, arst_n, yv, done, "result dropped")
endmodule
`default_nettype wire

// ===== test/planckian_locus_chromaticity_tb.sv =====
`timescale 1ns / 1ps
module planckian_locus_chromaticity_tb;
	import plc_pkg::*;

	localparam int Frac = 16;
	localparam int Latency = Frac + 11 + 8;
	localparam int WatchLimit = 20000;

	typedef struct {
		logic [TempW-1:0] temp;
		bit               known;
		logic [OutW-1:0]  x;
		logic [OutW-1:0]  y;
	} stim_row_t;

	typedef struct {
		logic [OutW-1:0] x;
		logic [OutW-1:0] y;
	} chroma_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [TempW-1:0] temp_kelvin;
	logic done;
	logic [OutW-1:0] chroma_x;
	logic [OutW-1:0] chroma_y;

	chroma_t pending_chroma[$];
	int errors;
	int idle_cycles;
	int sender_idle_pct;

	planckian_locus_chromaticity #(.FRAC_BITS(Frac)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.temp_kelvin(temp_kelvin), .done(done), .chroma_x(chroma_x), .chroma_y(chroma_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// coefficient tables scaled by 1e8: c3, c2, c1, c0
	function automatic longint coef(input int sel, input int k);
		longint t[5][4];
		longint dec;
		longint mag;
		longint r;
		t[0] = '{-26612390, -23435890, 87769560, 17991000};
		t[1] = '{-302584690, 210703790, 22263470, 24039000};
		t[2] = '{-110638140, -134811020, 218555832, -20219683};
		t[3] = '{-95494760, -137418593, 209137015, -16748867};
		t[4] = '{308175800, -587338670, 375112997, -37001483};
		dec = t[sel][k];
		mag = (dec < 0) ? -dec : dec;
		r = (mag * (longint'(1) << Frac) + 50000000) / 100000000;
		return (dec < 0) ? -r : r;
	endfunction

	// floor((v + half) / 2^Frac); arithmetic shift floors negatives
	function automatic longint round_q(input longint v);
		return (v + (longint'(1) << (Frac - 1))) >>> Frac;
	endfunction

	function automatic longint eval_cubic(input int sel, input longint p1);
		longint p2;
		longint p3;
		p2 = round_q(p1 * p1);
		p3 = round_q(p2 * p1);
		return round_q(coef(sel, 0) * p3 + coef(sel, 1) * p2 + coef(sel, 2) * p1
			+ coef(sel, 3) * (longint'(1) << Frac));
	endfunction

	function automatic longint clamp_unit(input longint v);
		longint top;
		top = (longint'(1) << Frac) - 1;
		if (v < 0) return 0;
		return (v > top) ? top : v;
	endfunction

	function automatic chroma_t locus_chroma(input logic [TempW-1:0] temp);
		longint umax;
		longint u;
		longint x;
		longint y;
		int ysel;
		chroma_t c;
		umax = (longint'(2) << Frac) - 1;
		if (temp == 0) u = umax;
		else begin
			u = ((longint'(1000) << Frac) + temp / 2) / temp;
			if (u > umax) u = umax;
		end
		x = clamp_unit(eval_cubic((temp < XSplit) ? 0 : 1, u));
		if (temp < YSplit) ysel = 2;
		else if (temp < XSplit) ysel = 3;
		else ysel = 4;
		y = clamp_unit(eval_cubic(ysel, x));
		c.x = x[OutW-1:0];
		c.y = y[OutW-1:0];
		return c;
	endfunction

	// check every result strobe against the oldest expectation
	always @(posedge clk) begin
		chroma_t e;
		if (arst_n && done) begin
			if (pending_chroma.size() == 0) begin
				$error("unexpected result x=%0d y=%0d", chroma_x, chroma_y);
				errors++;
			end else begin
				e = pending_chroma.pop_front();
				if (chroma_x !== e.x) begin
					$error("chroma_x expected %0d actual %0d", e.x, chroma_x);
					errors++;
				end
				if (chroma_y !== e.y) begin
					$error("chroma_y expected %0d actual %0d", e.y, chroma_y);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("planckian_locus_chromaticity_tb failed");
			$finish;
		end
	end

	// drive one transfer, with optional idle cycles before it
	task automatic send_temp(input logic [TempW-1:0] t, input chroma_t exp_c);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		temp_kelvin <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_chroma.push_back(exp_c);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_chroma.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	function automatic logic [TempW-1:0] rand_temp();
		int r;
		r = $urandom_range(99);
		if (r < 80) return TempW'($urandom_range(25000, 1000));
		if (r < 88) return TempW'($urandom_range(XSplit + 3, XSplit - 3));
		if (r < 94) return TempW'($urandom_range(YSplit + 3, YSplit - 3));
		return TempW'($urandom);
	endfunction

	initial begin
		stim_row_t rows[$];
		chroma_t c;
		int phase;
		errors = 0;
		idle_cycles = 0;
		sender_idle_pct = 0;
		start = 1'b0;
		temp_kelvin = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: zero and up to 500 K saturate u; rows at the splits;
		// out-of-range values extrapolate
		rows = '{
			'{15'd0, 0, 0, 0}, '{15'd1, 0, 0, 0}, '{15'd499, 0, 0, 0},
			'{15'd500, 0, 0, 0}, '{15'd1000, 0, 0, 0}, '{15'd2221, 0, 0, 0},
			'{15'd2222, 0, 0, 0}, '{15'd3999, 0, 0, 0}, '{15'd4000, 0, 0, 0},
			'{15'd6500, 0, 0, 0}, '{15'd25000, 0, 0, 0}, '{15'd25001, 0, 0, 0},
			'{15'h7FFF, 0, 0, 0}, '{15'h5555, 0, 0, 0}, '{15'h2AAA, 0, 0, 0}
		};
		foreach (rows[i]) begin
			if (rows[i].known) begin
				c.x = rows[i].x;
				c.y = rows[i].y;
			end else c = locus_chroma(rows[i].temp);
			send_temp(rows[i].temp, c);
		end
		// hold off until every result is back
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 84 : (phase == 3) ? 6 : 0;
			repeat (310) begin
				begin
					logic [TempW-1:0] t;
					t = rand_temp();
					send_temp(t, locus_chroma(t));
				end
			end
			if (phase == 1) drain_results();
		end
		drain_results();

		if (errors == 0) $display("planckian_locus_chromaticity_tb passed");
		else $display("planckian_locus_chromaticity_tb failed");
		$finish;
	end
endmodule
